// ===== rtl/ffra_pkg.sv =====
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared types and constants for the first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

    localparam int MaxRanges  = 64;
    localparam int OffBits    = 16;
    localparam int LenBits    = 17;
    localparam int CntBits    = $clog2(MaxRanges + 1);
    localparam int IdxBits    = $clog2(MaxRanges);

    localparam logic [LenBits-1:0] LenMax = '1;

    localparam logic [2:0] StOk    = 3'd0;
    localparam logic [2:0] StOom   = 3'd1;
    localparam logic [2:0] StNofit = 3'd2;
    localparam logic [2:0] StFull  = 3'd3;
    localparam logic [2:0] StDup   = 3'd4;

    localparam logic CmdAlloc   = 1'b0;
    localparam logic CmdRelease = 1'b1;

    // cell actions broadcast by the controller
    typedef enum logic [6:0] {
        OP_NONE    = 7'b0000001,
        OP_INIT    = 7'b0000010,
        OP_TRIM    = 7'b0000100,  // shrink entry from front
        OP_REMOVE  = 7'b0001000,  // delete entry, shift up
        OP_GROW    = 7'b0010000,  // set length of entry
        OP_SETNEXT = 7'b0100000,  // set start and length of entry
        OP_INSERT  = 7'b1000000   // insert entry, shift down
    } t_op;

    typedef struct packed {
        t_op                  op;
        logic [IdxBits-1:0]   idx;
        logic [OffBits-1:0]   start;
        logic [LenBits-1:0]   len;
    } t_cmd;

    typedef struct packed {
        logic [OffBits-1:0] start;
        logic [LenBits-1:0] len;
    } t_entry;

    function automatic logic [LenBits-1:0] sat_add(input logic [LenBits-1:0] a,
                                                   input logic [LenBits-1:0] b);
        logic [LenBits:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LenBits] ? LenMax : s[LenBits-1:0];
    endfunction

endpackage

// ===== rtl/ffra_cell.sv =====
// ----------------------------------------------------------------------------
// ffra_cell
// One table slot: holds a free range, compares it against the request and
// takes its neighbor's entry on shifts.
// ----------------------------------------------------------------------------
module ffra_cell (
    input  logic                                i_clk,
    input  logic [ffra_pkg::IdxBits-1:0]        i_my_idx,
    input  ffra_pkg::t_cmd                      i_cmd,
    input  ffra_pkg::t_entry                    i_prev,
    input  ffra_pkg::t_entry                    i_next,
    input  logic [ffra_pkg::LenBits-1:0]        i_req_size,
    input  logic [ffra_pkg::OffBits-1:0]        i_req_off,
    output ffra_pkg::t_entry                    o_entry,
    output logic                                o_fits,
    output logic                                o_below
);

    ffra_pkg::t_entry r_entry;
    ffra_pkg::t_entry n_entry;
    logic             w_sel;

    assign w_sel = (i_cmd.idx == i_my_idx);

    always_comb begin
        n_entry = r_entry;
        case (i_cmd.op)
            ffra_pkg::OP_INIT: begin
                if (w_sel) begin
                    n_entry.start = i_cmd.start;
                    n_entry.len   = i_cmd.len;
                end
            end
            ffra_pkg::OP_TRIM, ffra_pkg::OP_SETNEXT: begin
                if (w_sel) begin
                    n_entry.start = i_cmd.start;
                    n_entry.len   = i_cmd.len;
                end
            end
            ffra_pkg::OP_GROW: begin
                if (w_sel) n_entry.len = i_cmd.len;
            end
            ffra_pkg::OP_REMOVE: begin
                if (i_my_idx >= i_cmd.idx) n_entry = i_next;
            end
            ffra_pkg::OP_INSERT: begin
                if (w_sel) begin
                    n_entry.start = i_cmd.start;
                    n_entry.len   = i_cmd.len;
                end else if (i_my_idx > i_cmd.idx) begin
                    n_entry = i_prev;
                end
            end
            default: n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;
    assign o_fits  = (r_entry.len >= i_req_size);
    assign o_below = (r_entry.start < i_req_off);

endmodule

// ===== rtl/first_fit_range_allocator_core.sv =====
// ----------------------------------------------------------------------------
// first_fit_range_allocator_core
// Each beat passes S_IDLE (capture), S_SCAN (registered cell-row search),
// S_EXEC (table update, result registered) and S_OUT (result held until taken);
// a release that merges with both neighbors first does a second shift in S_OUT.
// A new beat is accepted only in S_IDLE, after the previous result is taken.
// Reset (sync, active low) and a pool_size write both load one free range.
// ----------------------------------------------------------------------------
module first_fit_range_allocator_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [16:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // command[0], request_size[17:1], release_offset[33:18]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [55:0] m_axis_tdata    // status[2:0], grant_offset[18:3], grant_size[35:19], free_bytes[52:36]
);
    localparam int N  = ffra_pkg::MaxRanges;
    localparam int IB = ffra_pkg::IdxBits;
    localparam int CB = ffra_pkg::CntBits;
    localparam int OB = ffra_pkg::OffBits;
    localparam int LB = ffra_pkg::LenBits;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_EXEC  = 4'b0100,
        S_OUT   = 4'b1000
    } t_state;

    t_state              r_state;
    logic                r_cmd;
    logic [LB-1:0]       r_size;
    logic [OB-1:0]       r_off;
    logic [CB-1:0]       r_count;
    logic [LB-1:0]       r_free;
    logic                r_init;
    logic [LB-1:0]       r_pool;
    logic [N-1:0]        r_fits, r_below;
    logic [2:0]          r_status;
    logic [OB-1:0]       r_goff;
    logic [LB-1:0]       r_gsize;
    ffra_pkg::t_cmd      w_cmd;

    ffra_pkg::t_entry    w_ent [N];
    logic [N-1:0]        w_fits, w_below;

    // second removal after a two-sided merge happens in S_OUT
    logic r_rm2;
    logic [IB-1:0] r_rm2_idx;

    genvar g;
    generate
        for (g = 0; g < N; g++) begin : g_cell
            ffra_pkg::t_entry w_p, w_n;
            assign w_p = (g == 0) ? w_ent[0] : w_ent[(g == 0) ? 0 : g-1];
            assign w_n = (g == N-1) ? w_ent[N-1] : w_ent[(g == N-1) ? N-1 : g+1];
            ffra_cell u_cell (
                .i_clk      (i_clk),
                .i_my_idx   (IB'(g)),
                .i_cmd      (w_cmd),
                .i_prev     (w_p),
                .i_next     (w_n),
                .i_req_size (r_size),
                .i_req_off  (r_off),
                .o_entry    (w_ent[g]),
                .o_fits     (w_fits[g]),
                .o_below    (w_below[g])
            );
        end
    endgenerate

    // first-fit index and insert position (first entry not below the offset)
    logic [N-1:0]  w_valid;
    logic          w_any_fit;
    logic [IB-1:0] w_fit_idx;
    logic [CB-1:0] w_pos;
    always_comb begin
        w_any_fit = 1'b0;
        w_fit_idx = '0;
        w_pos     = r_count;
        for (int i = 0; i < N; i++) begin
            w_valid[i] = (CB'(i) < r_count);
        end
        for (int i = N-1; i >= 0; i--) begin
            if (w_valid[i] && !r_below[i]) w_pos = CB'(i);
            if (w_valid[i] && r_fits[i]) begin
                w_any_fit = 1'b1;
                w_fit_idx = IB'(i);
            end
        end
    end

    // release/alloc decision
    logic [IB-1:0]     w_pidx, w_pm1;
    ffra_pkg::t_entry  w_at, w_pr, w_fe;
    logic              w_pin, w_dup, w_mnext, w_mprev;
    logic [LB:0]       w_pend, w_nend;
    always_comb begin
        w_pidx  = w_pos[IB-1:0];
        w_pm1   = w_pidx - IB'(1);
        w_at    = w_ent[w_pidx];
        w_pr    = w_ent[w_pm1];
        w_fe    = w_ent[w_fit_idx];
        w_pin   = (w_pos < r_count);
        w_dup   = w_pin && (w_at.start == r_off);
        w_nend  = (LB+1)'(r_off) + (LB+1)'(r_size);
        w_mnext = w_pin && (w_nend == (LB+1)'(w_at.start));
        w_pend  = (LB+1)'(w_pr.start) + (LB+1)'(w_pr.len);
        w_mprev = (w_pos != '0) && (w_pend == (LB+1)'(r_off));
    end

    always_comb begin
        w_cmd = '{op: ffra_pkg::OP_NONE, idx: '0, start: '0, len: '0};
        if (r_init) begin
            w_cmd = '{op: ffra_pkg::OP_INIT, idx: '0, start: '0, len: r_pool};
        end else if (r_rm2) begin
            w_cmd = '{op: ffra_pkg::OP_REMOVE, idx: r_rm2_idx, start: '0, len: '0};
        end else if (r_state == S_EXEC) begin
            if (r_cmd == ffra_pkg::CmdAlloc) begin
                if (r_size <= r_free && w_any_fit) begin
                    if (w_fe.len > r_size)
                        w_cmd = '{op: ffra_pkg::OP_TRIM, idx: w_fit_idx,
                                  start: OB'(LB'(w_fe.start) + r_size),
                                  len: w_fe.len - r_size};
                    else
                        w_cmd = '{op: ffra_pkg::OP_REMOVE, idx: w_fit_idx,
                                  start: '0, len: '0};
                end
            end else if (!w_dup) begin
                if (w_mprev && w_mnext)
                    w_cmd = '{op: ffra_pkg::OP_GROW, idx: w_pm1, start: '0,
                              len: ffra_pkg::sat_add(ffra_pkg::sat_add(w_pr.len, r_size),
                                                     w_at.len)};
                else if (w_mprev)
                    w_cmd = '{op: ffra_pkg::OP_GROW, idx: w_pm1, start: '0,
                              len: ffra_pkg::sat_add(w_pr.len, r_size)};
                else if (w_mnext)
                    w_cmd = '{op: ffra_pkg::OP_SETNEXT, idx: w_pidx, start: r_off,
                              len: ffra_pkg::sat_add(w_at.len, r_size)};
                else if (r_count < CB'(N))
                    w_cmd = '{op: ffra_pkg::OP_INSERT, idx: w_pidx, start: r_off,
                              len: r_size};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= CB'(1);
            r_free  <= LB'(65536);
            r_pool  <= LB'(65536);
            r_init  <= 1'b1;
            r_rm2   <= 1'b0;
        end else begin
            r_init <= 1'b0;
            if (i_cfg_we) begin
                r_pool  <= i_cfg_wdata;
                r_free  <= i_cfg_wdata;
                r_count <= CB'(1);
                r_init  <= 1'b1;
            end
            case (r_state)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_cmd   <= s_axis_tdata[0];
                        r_size  <= s_axis_tdata[17:1];
                        r_off   <= s_axis_tdata[33:18];
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_fits  <= w_fits;
                    r_below <= w_below;
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_goff  <= '0;
                    r_gsize <= '0;
                    r_status <= ffra_pkg::StOk;
                    if (r_cmd == ffra_pkg::CmdAlloc) begin
                        if (r_size > r_free) r_status <= ffra_pkg::StOom;
                        else if (!w_any_fit) r_status <= ffra_pkg::StNofit;
                        else begin
                            r_goff  <= w_fe.start;
                            r_gsize <= r_size;
                            r_free  <= r_free - r_size;
                            if (w_fe.len == r_size)
                                r_count <= r_count - CB'(1);
                        end
                    end else if (w_dup) begin
                        r_status <= ffra_pkg::StDup;
                    end else if (!w_mprev && !w_mnext && r_count >= CB'(N)) begin
                        r_status <= ffra_pkg::StFull;
                    end else begin
                        r_free <= ffra_pkg::sat_add(r_free, r_size);
                        if (w_mprev && w_mnext) begin
                            r_rm2     <= 1'b1;
                            r_rm2_idx <= w_pidx;
                            r_count   <= r_count - CB'(1);
                        end else if (!w_mprev && !w_mnext) begin
                            r_count <= r_count + CB'(1);
                        end
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (r_rm2) r_rm2 <= 1'b0;
                    else if (m_axis_tready) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = (r_state == S_OUT) && !r_rm2;
    assign m_axis_tdata  = {3'b000, r_free, r_gsize, r_goff, r_status};

    property p_no_overlap;
        @(posedge i_clk) disable iff (!i_rst_n) !(m_axis_tvalid && s_axis_tready);
    endproperty
    a_no_overlap: assert property (p_no_overlap) else $error("result and accept overlap");

    property p_cnt_range;
        @(posedge i_clk) disable iff (!i_rst_n) r_count <= CB'(N);
    endproperty
    a_cnt_range: assert property (p_cnt_range) else $error("count over depth");

    property p_scan_follows;
        @(posedge i_clk) disable iff (!i_rst_n)
            (r_state == S_SCAN) |=> (r_state == S_EXEC);
    endproperty
    a_scan_follows: assert property (p_scan_follows) else $error("scan not followed");

    property p_out_hold;
        @(posedge i_clk) disable iff (!i_rst_n)
            (m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata);
    endproperty
    a_out_hold: assert property (p_out_hold) else $error("result changed");

endmodule

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the first-fit range allocator. Drives allocate and
// release beats with random gaps and back-pressure, predicts every result
// from a free-range table kept in the bench, and compares each result beat.
// ----------------------------------------------------------------------------
class alloc_scoreboard;
    logic [ffra_pkg::OffBits-1:0] fr_start[$];
    logic [ffra_pkg::LenBits-1:0] fr_len[$];
    logic [ffra_pkg::LenBits-1:0] free_cnt;
    logic [55:0]                  pending[$];
    int                           mismatches;

    function void init_pool(logic [ffra_pkg::LenBits-1:0] size);
        fr_start = {};
        fr_len   = {};
        fr_start.push_back('0);
        fr_len.push_back(size);
        free_cnt = size;
    endfunction

    function logic [ffra_pkg::LenBits-1:0] sadd(logic [ffra_pkg::LenBits-1:0] a,
                                                logic [ffra_pkg::LenBits-1:0] b);
        logic [ffra_pkg::LenBits:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[ffra_pkg::LenBits] ? ffra_pkg::LenMax : s[ffra_pkg::LenBits-1:0];
    endfunction

    // predict the result of one accepted beat and update the table
    function void note_request(logic cmd, logic [ffra_pkg::LenBits-1:0] sz,
                               logic [ffra_pkg::OffBits-1:0] off);
        logic [2:0]                   st;
        logic [ffra_pkg::OffBits-1:0] goff;
        logic [ffra_pkg::LenBits-1:0] gsz;
        int                           pos;
        int                           n;
        bit                           mprev, mnext;
        st = ffra_pkg::StOk; goff = '0; gsz = '0;
        n = fr_start.size();
        if (cmd == ffra_pkg::CmdAlloc) begin
            if (sz > free_cnt) begin
                st = ffra_pkg::StOom;
            end else begin
                st = ffra_pkg::StNofit;
                for (int i = 0; i < n; i++) begin
                    if (fr_len[i] >= sz) begin
                        goff = fr_start[i];
                        gsz  = sz;
                        if (fr_len[i] > sz) begin
                            fr_start[i] = fr_start[i] + sz[ffra_pkg::OffBits-1:0];
                            fr_len[i]   = fr_len[i] - sz;
                        end else begin
                            fr_start.delete(i);
                            fr_len.delete(i);
                        end
                        free_cnt = free_cnt - sz;
                        st = ffra_pkg::StOk;
                        break;
                    end
                end
            end
        end else begin
            pos = 0;
            while (pos < n && fr_start[pos] < off) pos++;
            if (pos < n && fr_start[pos] == off) begin
                st = ffra_pkg::StDup;
            end else begin
                mnext = pos < n && ({1'b0, off} + sz) == {1'b0, fr_start[pos]};
                mprev = pos > 0 && ({1'b0, fr_start[pos-1]} + fr_len[pos-1]) == {1'b0, off};
                if (!mnext && !mprev && n >= ffra_pkg::MaxRanges) begin
                    st = ffra_pkg::StFull;
                end else begin
                    if (mprev && mnext) begin
                        fr_len[pos-1] = sadd(sadd(fr_len[pos-1], sz), fr_len[pos]);
                        fr_start.delete(pos);
                        fr_len.delete(pos);
                    end else if (mprev) begin
                        fr_len[pos-1] = sadd(fr_len[pos-1], sz);
                    end else if (mnext) begin
                        fr_start[pos] = off;
                        fr_len[pos]   = sadd(fr_len[pos], sz);
                    end else begin
                        fr_start.insert(pos, off);
                        fr_len.insert(pos, sz);
                    end
                    free_cnt = sadd(free_cnt, sz);
                end
            end
        end
        pending.push_back({3'b0, free_cnt, gsz, goff, st});
    endfunction

    function void check_result(logic [55:0] got);
        logic [55:0] exp;
        if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", got);
            return;
        end
        exp = pending.pop_front();
        if (got[2:0] !== exp[2:0] || got[18:3] !== exp[18:3] ||
            got[35:19] !== exp[35:19] || got[52:36] !== exp[52:36]) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: st %0d/%0d off %h/%h size %h/%h free %h/%h",
                         exp[2:0], got[2:0], exp[18:3], got[18:3],
                         exp[35:19], got[35:19], exp[52:36], got[52:36]);
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [16:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [55:0] m_axis_tdata;

    alloc_scoreboard sb;
    int          idle_cycles = 0;
    bit          rx_enable = 1'b0;

    always #1 i_clk = ~i_clk;

    first_fit_range_allocator_core u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // result side: random stalls, check on each accepted beat
    always @(posedge i_clk) begin
        if (m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata);
            m_axis_tready <= 1'b0;
        end else if (rx_enable && !m_axis_tready && $urandom_range(0, 3) == 0) begin
            m_axis_tready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // valid stays up into the next beat when no gap is drawn
    task automatic send_beat(logic cmd, logic [16:0] sz, logic [15:0] off);
        int gap;
        gap = $urandom_range(0, 3);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {6'b0, off, sz, cmd};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        sb.note_request(cmd, sz, off);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_pool(logic [16:0] size);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= size;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.init_pool(size);
    endtask

    // mostly plausible traffic: alloc, and release of chunks we were granted
    task automatic random_phase(int count, int max_sz);
        logic [15:0] held_off[$];
        logic [16:0] held_sz[$];
        int          k;
        logic [16:0] sz;
        for (int i = 0; i < count; i++) begin
            k = $urandom_range(0, 9);
            if (k < 5) begin
                sz = 17'($urandom_range(0, max_sz));
                send_beat(ffra_pkg::CmdAlloc, sz, 16'($urandom));
                if (sb.pending[$][2:0] == ffra_pkg::StOk && sz != 0) begin
                    held_off.push_back(sb.pending[$][18:3]);
                    held_sz.push_back(sz);
                end
            end else if (k < 9 && held_off.size() != 0) begin
                k = $urandom_range(0, held_off.size() - 1);
                send_beat(ffra_pkg::CmdRelease, held_sz[k], held_off[k]);
                held_off.delete(k);
                held_sz.delete(k);
            end else begin
                send_beat(1'($urandom_range(0, 1)), 17'($urandom), 16'($urandom));
            end
        end
    endtask

    initial begin
        sb = new();
        sb.init_pool(17'd65536);
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        rx_enable = 1'b1;
        @(posedge i_clk);

        // directed: extremes and special cases
        send_beat(ffra_pkg::CmdAlloc, 17'd0, 16'hFFFF);
        send_beat(ffra_pkg::CmdAlloc, 17'h1FFFF, '0);          // out of memory
        send_beat(ffra_pkg::CmdAlloc, 17'd100, '0);
        send_beat(ffra_pkg::CmdAlloc, 17'd200, '0);
        send_beat(ffra_pkg::CmdRelease, 17'd100, 16'd100);     // duplicate of free start? no: inserts
        send_beat(ffra_pkg::CmdRelease, 17'd5, 16'd100);       // duplicate release
        send_beat(ffra_pkg::CmdRelease, 17'd0, 16'd50);        // zero-size release
        send_beat(ffra_pkg::CmdAlloc, 17'd100, '0);            // exact fit removes entry
        send_beat(ffra_pkg::CmdRelease, 17'd100, 16'd0);       // inserts ahead of the zero-size range at 50
        send_beat(ffra_pkg::CmdRelease, 17'd100, 16'd0);
        send_beat(ffra_pkg::CmdAlloc, 17'd65536, '0);
        send_beat(ffra_pkg::CmdAlloc, 17'd1, '0);
        send_beat(ffra_pkg::CmdAlloc, 17'd0, '0);              // zero-size alloc
        send_beat(ffra_pkg::CmdRelease, 17'h1FFFF, 16'hFFFF);  // saturating sums
        send_beat(ffra_pkg::CmdRelease, 17'h1FFFF, 16'h0000);

        // fill the table to its limit: many isolated one-byte holes
        write_pool(17'd200);
        send_beat(ffra_pkg::CmdAlloc, 17'd200, '0);
        for (int i = 0; i < ffra_pkg::MaxRanges + 2; i++)
            send_beat(ffra_pkg::CmdRelease, 17'd1, 16'(2 * i));
        send_beat(ffra_pkg::CmdRelease, 17'd1, 16'd1);         // merges both sides
        send_beat(ffra_pkg::CmdAlloc, 17'd2, '0);              // takes two bytes from the merged range

        write_pool(17'd1);
        random_phase(150, 2);
        write_pool(17'd0);
        random_phase(50, 1);
        write_pool(17'h1FFFF);
        random_phase(250, 40000);
        write_pool(17'd65536);
        random_phase(400, 4000);
        drain();                                      // sender waits for all results
        write_pool(17'd3000);
        random_phase(250, 300);

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
